@@ rtl/u16u8_pkg.sv @@
`default_nettype none

package u16u8_pkg;

	localparam int UNIT_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int CP_W      = 21;
	localparam int MAX_BYTES = 6;
	localparam int ENC_BYTES = 4;
	localparam int CNT_W     = 3;
	localparam int ENC_LEN_W = 3;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = 1;
	localparam int QCNT_W    = 2;

	localparam logic [UNIT_W-1:0] SURR_HI_MIN = 16'hD800;
	localparam logic [UNIT_W-1:0] SURR_HI_MAX = 16'hDBFF;
	localparam logic [UNIT_W-1:0] SURR_LO_MIN = 16'hDC00;
	localparam logic [UNIT_W-1:0] SURR_LO_MAX = 16'hDFFF;
	localparam logic [CP_W-1:0]   CP_SUPP_BASE = 21'h10000;
	localparam logic [CP_W-1:0]   CP_MAX_1B    = 21'h7F;
	localparam logic [CP_W-1:0]   CP_MAX_2B    = 21'h7FF;
	localparam logic [CP_W-1:0]   CP_MAX_3B    = 21'hFFFF;
	localparam logic [BYTE_W-1:0] LEAD_2B      = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD_3B      = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD_4B      = 8'hF0;
	localparam logic [BYTE_W-1:0] CONT_B       = 8'h80;

	localparam logic [CNT_W-1:0] HELD_BYTES = 3'd3;

	typedef struct packed {
		logic [ENC_BYTES-1:0][BYTE_W-1:0] b;
		logic [ENC_LEN_W-1:0]             len;
	} enc_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
		logic [CNT_W-1:0]                 count;
		logic                             last;
	} job_t;

	function automatic enc_t encode_point(input logic [CP_W-1:0] cp);
		enc_t e;
		e = '0;
		if (cp <= CP_MAX_1B) begin
			e.b[0] = cp[7:0];
			e.len  = 3'd1;
		end else if (cp <= CP_MAX_2B) begin
			e.b[0] = LEAD_2B | {3'b000, cp[10:6]};
			e.b[1] = CONT_B | {2'b00, cp[5:0]};
			e.len  = 3'd2;
		end else if (cp <= CP_MAX_3B) begin
			e.b[0] = LEAD_3B | {4'b0000, cp[15:12]};
			e.b[1] = CONT_B | {2'b00, cp[11:6]};
			e.b[2] = CONT_B | {2'b00, cp[5:0]};
			e.len  = 3'd3;
		end else begin
			e.b[0] = LEAD_4B | {5'b00000, cp[20:18]};
			e.b[1] = CONT_B | {2'b00, cp[17:12]};
			e.b[2] = CONT_B | {2'b00, cp[11:6]};
			e.b[3] = CONT_B | {2'b00, cp[5:0]};
			e.len  = 3'd4;
		end
		return e;
	endfunction

endpackage

`default_nettype wire

@@ rtl/u16u8_if.sv @@
`default_nettype none

interface u16u8_in_if;
	import u16u8_pkg::*;

	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] code_unit;
	logic              end_of_input;

	modport source(output valid, output code_unit, output end_of_input, input ready);
	modport sink(input valid, input code_unit, input end_of_input, output ready);
endinterface

interface u16u8_out_if;
	import u16u8_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              run_last;
	logic              string_end;

	modport source(output valid, output out_byte, output run_last, output string_end,
		input ready);
	modport sink(input valid, input out_byte, input run_last, input string_end,
		output ready);
endinterface

`default_nettype wire

@@ rtl/utf16_to_utf8_encoder_unit.sv @@
// UTF-16 to UTF-8 transcoder.
// unit_in takes one UTF-16 code unit per transfer, with end_of_input set on
// the final unit of a string. byte_out gives one UTF-8 byte per transfer;
// run_last marks the last byte caused by an input unit and string_end the
// last byte of the string. A high surrogate that is not the final unit is
// kept until the next unit: a following low surrogate makes a 4-byte sequence,
// anything else sends it as 3 bytes first. Lone surrogates give 3 bytes each.
// The front stage classifies a unit and builds all its bytes (up to six) in
// the cycle it is accepted; a two-entry job queue feeds the back stage, which
// sends one byte per cycle from an output register while byte_out is ready.
// The first byte of a unit is written into a queue entry and then loaded
// into the output register before byte_out shows it.
// Throughput: one byte per cycle while byte_out is ready; a unit gives 1 to 3
// bytes (most units) or up to 6, and a unit that is only kept gives none.
// Reset clears the kept surrogate and empties the queue and the output register.
// When byte_out stalls the output register holds, the queue fills and
// unit_in.ready drops once both queue entries are taken.
`default_nettype none

module utf16_to_utf8_encoder_unit (
	input  wire          clk,
	input  wire          arst_n,
	u16u8_in_if.sink     unit_in,
	u16u8_out_if.source  byte_out
);
	import u16u8_pkg::*;

	job_t job;
	job_t head_job;
	logic push;
	logic full;
	logic head_valid;
	logic pop;

	u16u8_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.unit_in (unit_in),
		.q_full  (full),
		.push    (push),
		.job     (job)
	);

	u16u8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (job),
		.full       (full),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop)
	);

	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.byte_out   (byte_out)
	);

endmodule

`default_nettype wire

@@ rtl/u16u8_front.sv @@
`default_nettype none

module u16u8_front (
	input  wire               clk,
	input  wire               arst_n,
	u16u8_in_if.sink          unit_in,
	input  wire               q_full,
	output logic              push,
	output u16u8_pkg::job_t   job
);
	import u16u8_pkg::*;

	logic              held_valid_q;
	logic [UNIT_W-1:0] held_high_q;
	logic              accept;
	logic              is_high;
	logic              is_low;
	logic              pair;
	logic              lead_held;
	logic              emit_unit;
	logic [CP_W-1:0]   cp_unit;
	enc_t              enc_held;
	enc_t              enc_unit;

	assign unit_in.ready = !q_full;
	assign accept        = unit_in.valid && unit_in.ready;

	always_comb begin
		is_high   = unit_in.code_unit >= SURR_HI_MIN && unit_in.code_unit <= SURR_HI_MAX;
		is_low    = unit_in.code_unit >= SURR_LO_MIN && unit_in.code_unit <= SURR_LO_MAX;
		pair      = held_valid_q && is_low;
		lead_held = held_valid_q && !pair;
		emit_unit = pair || !(is_high && !unit_in.end_of_input);
		cp_unit   = pair ? CP_SUPP_BASE + {1'b0, held_high_q[9:0], unit_in.code_unit[9:0]}
		                 : {5'b00000, unit_in.code_unit};
		enc_held  = encode_point({5'b00000, held_high_q});
		enc_unit  = encode_point(cp_unit);

		job.last = unit_in.end_of_input;
		if (lead_held) begin
			job.bytes = {enc_unit.b[2:0], enc_held.b[2:0]};
			job.count = HELD_BYTES + (emit_unit ? enc_unit.len : 3'd0);
		end else begin
			job.bytes = {16'h0000, enc_unit.b};
			job.count = emit_unit ? enc_unit.len : 3'd0;
		end
		push = accept && (job.count != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_high_q  <= '0;
		end else if (accept) begin
			if (!pair && is_high && !unit_in.end_of_input) begin
				held_valid_q <= 1'b1;
				held_high_q  <= unit_in.code_unit;
			end else begin
				held_valid_q <= 1'b0;
				held_high_q  <= '0;
			end
		end
	end

	// end of string always leaves the hold empty
	a_clear_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && unit_in.end_of_input) |=> !held_valid_q)
		else $error("hold not cleared at end of string");

	// an item that only holds a surrogate makes no transfer into the queue
	a_hold_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !held_valid_q && is_high && !unit_in.end_of_input) |-> !push)
		else $error("held surrogate pushed bytes");

endmodule

`default_nettype wire

@@ rtl/u16u8_queue.sv @@
`default_nettype none

module u16u8_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  u16u8_pkg::job_t   push_job,
	output logic              full,
	output logic              head_valid,
	output u16u8_pkg::job_t   head_job,
	input  wire               pop
);
	import u16u8_pkg::*;

	job_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = cnt_q == QCNT_W'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head_job   = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push while queue full");

endmodule

`default_nettype wire

@@ rtl/u16u8_back.sv @@
`default_nettype none

module u16u8_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               head_valid,
	input  u16u8_pkg::job_t   head_job,
	output logic              pop,
	u16u8_out_if.source       byte_out
);
	import u16u8_pkg::*;

	logic [CNT_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              run_last_q;
	logic              string_end_q;
	logic              load;
	logic              final_byte;

	assign load       = head_valid && (!out_valid_q || byte_out.ready);
	assign final_byte = CNT_W'(idx_q + 1'b1) == head_job.count;
	assign pop        = load && final_byte;

	assign byte_out.valid      = out_valid_q;
	assign byte_out.out_byte   = out_byte_q;
	assign byte_out.run_last   = run_last_q;
	assign byte_out.string_end = string_end_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= head_job.bytes[idx_q];
			run_last_q   <= final_byte;
			string_end_q <= final_byte && head_job.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_byte ? '0 : CNT_W'(idx_q + 1'b1);
			end else if (byte_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q < head_job.count)
		else $error("byte index past job length");

endmodule

`default_nettype wire

@@ sim/utf16_to_utf8_encoder_unit_tb.sv @@
`timescale 1ns / 100ps

module utf16_to_utf8_encoder_unit_tb;
	import u16u8_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              run_last;
		logic              string_end;
	} utf8_byte_t;

	// first byte leftmost in bytes; with fixed set, count 0 means the unit is only held
	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic              eoi;
		logic              fixed;
		logic [2:0]        count;
		logic [47:0]       bytes;
	} stim_row_t;

	localparam int N_DIRECTED = 25;
	localparam int N_RANDOM   = 260;

	localparam stim_row_t DIRECTED [0:N_DIRECTED-1] = '{
		'{16'h0000, 1'b0, 1'b1, 3'd1, 48'h00_0000000000},
		'{16'h007F, 1'b0, 1'b1, 3'd1, 48'h7F_0000000000},
		'{16'h0080, 1'b0, 1'b1, 3'd2, 48'hC280_00000000},
		'{16'h07FF, 1'b0, 1'b1, 3'd2, 48'hDFBF_00000000},
		'{16'h0800, 1'b0, 1'b1, 3'd3, 48'hE0A080_000000},
		'{16'hFFFF, 1'b1, 1'b1, 3'd3, 48'hEFBFBF_000000},
		'{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0},
		'{16'hDC00, 1'b0, 1'b1, 3'd4, 48'hF0908080_0000},
		'{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h0},
		'{16'hDFFF, 1'b1, 1'b1, 3'd4, 48'hF48FBFBF_0000},
		'{16'hDC00, 1'b0, 1'b1, 3'd3, 48'hEDB080_000000},
		'{16'hDFFF, 1'b0, 1'b0, 3'd0, 48'h0},
		'{16'hD800, 1'b1, 1'b1, 3'd3, 48'hEDA080_000000},
		'{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0},
		'{16'h0041, 1'b0, 1'b1, 3'd4, 48'hEDA08041_0000},
		'{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h0},
		'{16'hDBFF, 1'b0, 1'b1, 3'd3, 48'hEDAFBF_000000},
		'{16'hDBFF, 1'b1, 1'b1, 3'd6, 48'hEDAFBF_EDAFBF},
		'{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0},
		'{16'hFFFF, 1'b0, 1'b1, 3'd6, 48'hEDA080_EFBFBF},
		'{16'h5555, 1'b0, 1'b0, 3'd0, 48'h0},
		'{16'hAAAA, 1'b0, 1'b0, 3'd0, 48'h0},
		'{16'hDAAA, 1'b0, 1'b0, 3'd0, 48'h0},
		'{16'hDD55, 1'b1, 1'b0, 3'd0, 48'h0},
		'{16'hE000, 1'b0, 1'b0, 3'd0, 48'h0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   no_idle = 1'b0;

	u16u8_in_if  unit_in_bus ();
	u16u8_out_if byte_out_bus ();

	utf16_to_utf8_encoder_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.unit_in  (unit_in_bus.sink),
		.byte_out (byte_out_bus.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// transcoder state
	logic              hold_valid;
	logic [UNIT_W-1:0] hold_unit;

	utf8_byte_t utf8_expected [$];
	utf8_byte_t step_bytes [$];

	int units_sent;
	int bytes_checked;
	int pairs_joined;
	int mismatches;

	function automatic void push_byte(input logic [7:0] b);
		utf8_byte_t x;
		x.data = b;
		x.run_last = 1'b0;
		x.string_end = 1'b0;
		step_bytes.insert(step_bytes.size(), x);
	endfunction

	function automatic void emit_point(input logic [20:0] cp);
		if (cp <= 21'h7F) begin
			push_byte(cp[7:0]);
		end else if (cp <= 21'h7FF) begin
			push_byte(8'hC0 | {3'b000, cp[10:6]});
			push_byte(8'h80 | {2'b00, cp[5:0]});
		end else if (cp <= 21'hFFFF) begin
			push_byte(8'hE0 | {4'b0000, cp[15:12]});
			push_byte(8'h80 | {2'b00, cp[11:6]});
			push_byte(8'h80 | {2'b00, cp[5:0]});
		end else begin
			push_byte(8'hF0 | {5'b00000, cp[20:18]});
			push_byte(8'h80 | {2'b00, cp[17:12]});
			push_byte(8'h80 | {2'b00, cp[11:6]});
			push_byte(8'h80 | {2'b00, cp[5:0]});
		end
	endfunction

	function automatic void transcode_unit(input logic [UNIT_W-1:0] u, input logic e);
		logic       is_high;
		logic       is_low;
		logic [20:0] cp;
		is_high = (u >= 16'hD800) && (u <= 16'hDBFF);
		is_low = (u >= 16'hDC00) && (u <= 16'hDFFF);
		step_bytes.delete();
		if (hold_valid && is_low) begin
			cp = 21'h10000 + ((21'(hold_unit) - 21'hD800) << 10) + (21'(u) - 21'hDC00);
			hold_valid = 1'b0;
			hold_unit = '0;
			pairs_joined++;
			emit_point(cp);
		end else begin
			if (hold_valid) begin
				emit_point(21'(hold_unit));
				hold_valid = 1'b0;
				hold_unit = '0;
			end
			if (is_high && !e) begin
				hold_valid = 1'b1;
				hold_unit = u;
			end else begin
				emit_point(21'(u));
			end
		end
		if (step_bytes.size() > 0) begin
			step_bytes[step_bytes.size()-1].run_last = 1'b1;
			step_bytes[step_bytes.size()-1].string_end = e;
		end
	endfunction

	task automatic send_unit(input logic [UNIT_W-1:0] u, input logic e, input logic fixed,
		input logic [2:0] n, input logic [47:0] fixed_bytes);
		int gap;
		utf8_byte_t b;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			unit_in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		unit_in_bus.valid <= 1'b1;
		unit_in_bus.code_unit <= u;
		unit_in_bus.end_of_input <= e;
		do @(posedge clk); while (!unit_in_bus.ready);
		units_sent++;
		transcode_unit(u, e);
		if (fixed) begin
			for (int k = 0; k < n; k++) begin
				b.data = fixed_bytes[47 - 8*k -: 8];
				b.run_last = (k == n - 1);
				b.string_end = (k == n - 1) && e;
				utf8_expected.insert(utf8_expected.size(), b);
			end
		end else begin
			foreach (step_bytes[k])
				utf8_expected.insert(utf8_expected.size(), step_bytes[k]);
		end
	endtask

	task automatic send_random_unit();
		int kind;
		logic e;
		logic [UNIT_W-1:0] u;
		kind = $urandom_range(0, 99);
		e = ($urandom_range(0, 7) == 0);
		if (kind < 20) begin
			u = 16'($urandom_range(0, 16'h7F));
		end else if (kind < 35) begin
			u = 16'($urandom_range(16'h80, 16'h7FF));
		end else if (kind < 55) begin
			u = $urandom_range(0, 1) ? 16'($urandom_range(16'h800, 16'hD7FF))
				: 16'($urandom_range(16'hE000, 16'hFFFF));
		end else if (kind < 80) begin
			// pair: high then low, well-formed unless the high unit carries end_of_input
			send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), $urandom_range(0, 15) == 0,
				1'b0, 3'd0, 48'h0);
			u = 16'($urandom_range(16'hDC00, 16'hDFFF));
		end else if (kind < 90) begin
			u = 16'($urandom_range(16'hD800, 16'hDBFF));
		end else if (kind < 95) begin
			u = 16'($urandom_range(16'hDC00, 16'hDFFF));
		end else begin
			u = 16'($urandom());
		end
		send_unit(u, e, 1'b0, 3'd0, 48'h0);
	endtask

	initial begin : byte_sink
		int stall;
		utf8_byte_t want;
		byte_out_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				byte_out_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			byte_out_bus.ready <= 1'b1;
			do @(posedge clk); while (!byte_out_bus.valid);
			if (utf8_expected.size() == 0) begin
				$error("unexpected transfer: out_byte %02h", byte_out_bus.out_byte);
				mismatches++;
			end else begin
				want = utf8_expected.pop_front();
				bytes_checked++;
				if (byte_out_bus.out_byte !== want.data) begin
					$error("out_byte: expected %02h, got %02h", want.data,
						byte_out_bus.out_byte);
					mismatches++;
				end
				if (byte_out_bus.run_last !== want.run_last) begin
					$error("run_last: expected %0b, got %0b", want.run_last,
						byte_out_bus.run_last);
					mismatches++;
				end
				if (byte_out_bus.string_end !== want.string_end) begin
					$error("string_end: expected %0b, got %0b", want.string_end,
						byte_out_bus.string_end);
					mismatches++;
				end
			end
		end
	end

	initial begin : unit_source
		hold_valid = 1'b0;
		hold_unit = '0;
		units_sent = 0;
		bytes_checked = 0;
		pairs_joined = 0;
		mismatches = 0;
		unit_in_bus.valid = 1'b0;
		unit_in_bus.code_unit = '0;
		unit_in_bus.end_of_input = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			send_unit(DIRECTED[i].unit, DIRECTED[i].eoi, DIRECTED[i].fixed,
				DIRECTED[i].count, DIRECTED[i].bytes);

		// blocks of 40 random draws (a pair draw sends two units), every fourth one without idling on either side
		for (int i = 0; i < N_RANDOM; i++) begin
			no_idle = ((i / 40) % 4 == 3);
			send_random_unit();
		end
		no_idle = 1'b0;
		unit_in_bus.valid <= 1'b0;

		while (utf8_expected.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d code units (%0d directed), %0d surrogate pairs joined",
			units_sent, N_DIRECTED, pairs_joined);
		$display("checked %0d UTF-8 bytes, %0d mismatches", bytes_checked, mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ files.f @@
rtl/u16u8_pkg.sv
rtl/u16u8_if.sv
rtl/u16u8_front.sv
rtl/u16u8_queue.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_encoder_unit.sv
sim/utf16_to_utf8_encoder_unit_tb.sv
